@@ rtl/core/ndr_pkg.sv @@
// Shared types and constants of the nine-bit datagram receiver.
package ndr_pkg;

   localparam int POS_W = 5;
   localparam int COUNT_W = 32;

   localparam logic [7:0] ESC_BYTE = 8'hFF;
   localparam logic [7:0] MARK_BYTE = 8'h00;
   localparam logic [7:0] NOT_SYNCED = 8'd255;
   localparam logic [7:0] LENGTH_DUE = 8'd254;
   localparam logic [7:0] LENGTH_BIAS = 8'd2;
   localparam logic [3:0] LENGTH_MASK = 4'hF;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_COLLISION = 2'd1,
      KIND_ESCAPE = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      MODE_PLAIN = 2'd0,
      MODE_ESCAPE = 2'd1,
      MODE_MARKED = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STATUS,
      ST_READ,
      ST_LOAD
   } ctl_state_type;

   typedef struct packed {
      logic [7:0] raw_byte;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [7:0] sentence_byte;
      logic [POS_W-1:0] byte_position;
      logic last_of_run;
      logic [COUNT_W-1:0] collision_total;
   } rsp_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;
      logic rd_en;
      logic load_status;
      logic load_byte;
      logic emit_inc;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic has_status;
      logic complete;
      logic out_free;
      logic emit_last;
   } dp_status_type;

endpackage

@@ rtl/core/ndr_req_if.sv @@
// Input channel carrying raw received bytes.
interface ndr_req_if import ndr_pkg::*; ();
   logic valid;
   logic ready;
   req_payload_type payload;

   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

@@ rtl/core/ndr_rsp_if.sv @@
// Result channel carrying datagram bytes and status results.
interface ndr_rsp_if import ndr_pkg::*; ();
   logic valid;
   logic ready;
   rsp_payload_type payload;

   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

@@ rtl/core/ndr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ndr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 18
) (
   input logic clock,
   input logic wr_en,
   input logic [$clog2(DEPTH)-1:0] wr_addr,
   input logic [WIDTH-1:0] wr_data,
   input logic rd_en,
   input logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/ndr_ctrl.sv @@
// Controller state machine: accepts bytes and sequences result transfers.
module ndr_ctrl import ndr_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input dp_status_type status,
   output ctl_cmd_type cmd
);

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      req_ready = 1'b0;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               if (status.has_status) begin
                  state_in = ST_STATUS;
               end else if (status.complete) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_STATUS: begin
            if (status.out_free) begin
               cmd.load_status = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (status.out_free) begin
               cmd.load_byte = 1'b1;
               if (status.emit_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.emit_inc = 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/core/ndr_datapath.sv @@
// Datapath: escape decoding, framing state, datagram store and output register.
module ndr_datapath import ndr_pkg::*; #(
   parameter int MAX_SENTENCE = 18
) (
   input logic clock,
   input logic reset,
   input ctl_cmd_type cmd,
   output dp_status_type status,
   input logic [7:0] req_byte,
   output logic rsp_valid,
   input logic rsp_ready,
   output rsp_payload_type rsp_payload
);

   localparam int FW = $clog2(MAX_SENTENCE + 1);
   localparam int AW = $clog2(MAX_SENTENCE);

   mode_type mode_ff, mode_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [7:0] rem_ff, rem_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [AW-1:0] emit_ff, emit_in;
   kind_type pend_kind_ff, pend_kind_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_payload_type out_ff, out_in;

   logic is_cmd, is_data, is_illegal;
   logic even_parity, collision, data_ok;
   logic [7:0] rem_eff, rem_dec;
   logic wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0] rd_data;

   assign even_parity = ~^req_byte;

   // Classify the incoming byte from the escape mode.
   always_comb begin
      is_cmd = 1'b0;
      is_data = 1'b0;
      is_illegal = 1'b0;
      mode_in = MODE_PLAIN;
      case (mode_ff)
         MODE_ESCAPE: begin
            if (req_byte == MARK_BYTE) begin
               mode_in = MODE_MARKED;
            end else if (req_byte == ESC_BYTE) begin
               is_data = 1'b1;
            end else begin
               is_illegal = 1'b1;
            end
         end
         MODE_MARKED: begin
            is_data = even_parity;
            is_cmd = ~even_parity;
         end
         default: begin
            if (req_byte == ESC_BYTE) begin
               mode_in = MODE_ESCAPE;
            end else begin
               is_cmd = even_parity;
               is_data = ~even_parity;
            end
         end
      endcase
   end

   assign collision = is_cmd && (rem_ff != 8'd0) && (rem_ff < LENGTH_DUE);
   assign data_ok = is_data && (fill_ff < FW'(MAX_SENTENCE)) && (rem_ff != 8'd0)
                    && (rem_ff != NOT_SYNCED);
   assign rem_eff = (rem_ff == LENGTH_DUE) ?
                    (LENGTH_BIAS + {4'd0, req_byte[3:0] & LENGTH_MASK}) : rem_ff;
   assign rem_dec = rem_eff - 8'd1;

   assign wr_en = cmd.take && (is_cmd || data_ok);
   assign wr_addr = is_cmd ? '0 : fill_ff[AW-1:0];

   always_comb begin
      fill_in = fill_ff;
      rem_in = rem_ff;
      count_in = count_ff;
      emit_in = emit_ff;
      pend_kind_in = pend_kind_ff;
      if (cmd.take) begin
         emit_in = '0;
         pend_kind_in = is_illegal ? KIND_ESCAPE : KIND_COLLISION;
         if (is_cmd) begin
            fill_in = FW'(1);
            rem_in = LENGTH_DUE;
            if (collision) begin
               count_in = count_ff + COUNT_W'(1);
            end
         end else if (data_ok) begin
            fill_in = fill_ff + FW'(1);
            rem_in = rem_dec;
         end
      end else if (cmd.emit_inc) begin
         emit_in = emit_ff + AW'(1);
      end
   end

   assign status.has_status = collision || is_illegal;
   assign status.complete = data_ok && (rem_dec == 8'd0);
   assign status.out_free = ~rsp_valid_ff || rsp_ready;
   assign status.emit_last = (FW'(emit_ff) + FW'(1)) == fill_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && ~rsp_ready;
      out_in = out_ff;
      if (cmd.load_status) begin
         rsp_valid_in = 1'b1;
         out_in.result_kind = pend_kind_ff;
         out_in.sentence_byte = '0;
         out_in.byte_position = '0;
         out_in.last_of_run = 1'b1;
         out_in.collision_total = count_ff;
      end else if (cmd.load_byte) begin
         rsp_valid_in = 1'b1;
         out_in.result_kind = KIND_DATA;
         out_in.sentence_byte = rd_data;
         out_in.byte_position = POS_W'(emit_ff);
         out_in.last_of_run = status.emit_last;
         out_in.collision_total = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PLAIN;
         fill_ff <= '0;
         rem_ff <= NOT_SYNCED;
         count_ff <= '0;
         emit_ff <= '0;
         pend_kind_ff <= KIND_COLLISION;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.take) begin
            mode_ff <= mode_in;
         end
         fill_ff <= fill_in;
         rem_ff <= rem_in;
         count_ff <= count_in;
         emit_ff <= emit_in;
         pend_kind_ff <= pend_kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   ndr_ram #(
      .WIDTH(8),
      .DEPTH(MAX_SENTENCE)
   ) u_store (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(req_byte),
      .rd_en(cmd.rd_en),
      .rd_addr(emit_ff),
      .rd_data(rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = out_ff;

endmodule

@@ rtl/core/nine_bit_datagram_receiver_core.sv @@
// Top level of the nine-bit datagram receiver: byte deframer with datagram store.
// A byte that causes no result leaves the controller ready for the next byte; a status
// result is loaded from ST_STATUS once the output register is free. A completing byte
// delivers its datagram of N bytes, each by a store read in ST_READ and a load in ST_LOAD.
// Reset is synchronous and active high; it clears the framing state, the collision count
// and the output valid flag. The datagram store holds no reset value and needs none.
module nine_bit_datagram_receiver_core import ndr_pkg::*; #(
   parameter int MAX_SENTENCE = 18
) (
   input logic clock,
   input logic reset,
   ndr_req_if.sink req_if,
   ndr_rsp_if.source rsp_if
);

   // The controller owns the handshake on the input side and decides, from the
   // datapath's classification of the current byte, whether a status result or a
   // whole datagram must follow. The datapath holds the framing state, the store
   // and the output register, which lets the next byte be taken while the last
   // result still waits for its transfer.
   ctl_cmd_type cmd;
   dp_status_type status;

   ndr_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_if.valid),
      .req_ready(req_if.ready),
      .status(status),
      .cmd(cmd)
   );

   ndr_datapath #(
      .MAX_SENTENCE(MAX_SENTENCE)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .req_byte(req_if.payload.raw_byte),
      .rsp_valid(rsp_if.valid),
      .rsp_ready(rsp_if.ready),
      .rsp_payload(rsp_if.payload)
   );

endmodule
